>>> rtl/core/pbqe_pkg.sv
// ----------------------------------------------------------------------------
// pbqe_pkg: shared types and constants of the billboard quad expander
// Field widths, command codes, pipeline structs and the atlas reciprocal table.
// ----------------------------------------------------------------------------
`default_nettype none

package pbqe_pkg;

   // Field widths
   localparam int unsigned COORD_W    = 32;
   localparam int unsigned AGE_W      = 16;
   localparam int unsigned SLOT_W     = 14;
   localparam int unsigned COEFF_W    = 4;
   localparam int unsigned ROWS_W     = 5;
   localparam int unsigned TEX_W      = 17;
   localparam int unsigned VNUM_W     = 16;
   localparam int unsigned REQ_DATA_W = 200;
   localparam int unsigned RSP_DATA_W = 152;

   // Arithmetic widths: transformed sums, quotient bits, lanes divided by w
   localparam int unsigned PROD_W   = 64;
   localparam int unsigned SUM_W    = 49;
   localparam int unsigned QUO_W    = 48;
   localparam int unsigned LANES    = 3;
   localparam int unsigned RECIP_W  = 27;
   localparam int unsigned RECIP_SH = 10;

   // Identity diagonal word in Q16.16
   localparam logic [COORD_W-1:0] ONE_Q16 = 32'h0001_0000;

   typedef enum logic {
      CMD_LOAD   = 1'b0,
      CMD_EXPAND = 1'b1
   } cmd_type;

   // Per-particle sideband carried alongside the divider
   typedef struct packed {
      logic signed [COORD_W-1:0] size;
      logic [TEX_W-1:0]          u0;
      logic [TEX_W-1:0]          u1;
      logic [TEX_W-1:0]          v0;
      logic [TEX_W-1:0]          v1;
      logic [SLOT_W-1:0]         slot;
      logic                      fault;
      logic [LANES-1:0]          neg;
      logic [LANES-1:0]          sat;
      logic [LANES-1:0]          zero;
   } side_type;

   typedef struct packed {
      logic                        valid;
      logic [LANES-1:0][SUM_W-1:0] num;
      logic [SUM_W-1:0]            den;
      side_type                    side;
   } div_in_type;

   typedef struct packed {
      logic                        valid;
      logic [LANES-1:0][QUO_W-1:0] quo;
      side_type                    side;
   } div_out_type;

   // ceil(2^26 / rows); floor(k*2^16/rows) = (k * entry) >> 10 for k below 32
   function automatic logic [RECIP_W-1:0] recip_lookup(input logic [ROWS_W-1:0] rows);
      logic [RECIP_W-1:0] r;
      unique case (rows)
         5'd0:  r = 27'd67108864;
         5'd1:  r = 27'd67108864;
         5'd2:  r = 27'd33554432;
         5'd3:  r = 27'd22369622;
         5'd4:  r = 27'd16777216;
         5'd5:  r = 27'd13421773;
         5'd6:  r = 27'd11184811;
         5'd7:  r = 27'd9586981;
         5'd8:  r = 27'd8388608;
         5'd9:  r = 27'd7456541;
         5'd10: r = 27'd6710887;
         5'd11: r = 27'd6100806;
         5'd12: r = 27'd5592406;
         5'd13: r = 27'd5162221;
         5'd14: r = 27'd4793491;
         5'd15: r = 27'd4473925;
         5'd16: r = 27'd4194304;
         5'd17: r = 27'd3947581;
         5'd18: r = 27'd3728271;
         5'd19: r = 27'd3532046;
         5'd20: r = 27'd3355444;
         5'd21: r = 27'd3195661;
         5'd22: r = 27'd3050403;
         5'd23: r = 27'd2917777;
         5'd24: r = 27'd2796203;
         5'd25: r = 27'd2684355;
         5'd26: r = 27'd2581111;
         5'd27: r = 27'd2485514;
         5'd28: r = 27'd2396746;
         5'd29: r = 27'd2314099;
         5'd30: r = 27'd2236963;
         5'd31: r = 27'd2164803;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/pbqe_front.sv
// ----------------------------------------------------------------------------
// pbqe_front: matrix store, point transform and atlas cell stages
// Four register stages: products, sums, magnitudes, saturation and texture.
// ----------------------------------------------------------------------------
`default_nettype none

module pbqe_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                adv,
   input  logic                                load_en,
   input  logic [pbqe_pkg::COEFF_W-1:0]        load_slot,
   input  logic [pbqe_pkg::COORD_W-1:0]        load_value,
   input  logic                                item_en,
   input  logic signed [pbqe_pkg::COORD_W-1:0] pos_x,
   input  logic signed [pbqe_pkg::COORD_W-1:0] pos_y,
   input  logic signed [pbqe_pkg::COORD_W-1:0] pos_z,
   input  logic signed [pbqe_pkg::COORD_W-1:0] half_size,
   input  logic [pbqe_pkg::AGE_W-1:0]          age,
   input  logic [pbqe_pkg::SLOT_W-1:0]         particle_slot,
   input  logic [pbqe_pkg::ROWS_W-1:0]         atlas_rows,
   output pbqe_pkg::div_in_type                div_in
);

   localparam int unsigned CW = pbqe_pkg::COORD_W;
   localparam int unsigned SW = pbqe_pkg::SUM_W;
   localparam int unsigned RW = pbqe_pkg::ROWS_W;
   localparam int unsigned TW = pbqe_pkg::TEX_W;
   localparam int unsigned AR_W = pbqe_pkg::AGE_W + RW;
   localparam int unsigned CELL_W = 2 * RW;
   localparam int unsigned KP_W = RW + 1 + pbqe_pkg::RECIP_W;

   // Matrix words, row times four plus column
   logic [15:0][CW-1:0] matrix_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 16; i++) begin
            matrix_ff[i] <= (i % 5 == 0) ? pbqe_pkg::ONE_Q16 : '0;
         end
      end else if (load_en) begin
         matrix_ff[load_slot] <= load_value;
      end
   end

   // Stage 1: twelve products, translation row, age times rows
   logic signed [CW-1:0]                  pos [3];
   logic signed [pbqe_pkg::PROD_W-1:0]    prod_ff [3][4];
   logic signed [CW-1:0]                  bias_ff [4];
   logic signed [CW-1:0]                  size1_ff;
   logic [pbqe_pkg::SLOT_W-1:0]           slot1_ff;
   logic [AR_W-1:0]                       ar1_ff;
   logic [RW-1:0]                         rows1_ff;
   logic [RW-1:0]                         rows_eff;
   logic                                  v1_ff;

   assign pos[0]   = pos_x;
   assign pos[1]   = pos_y;
   assign pos[2]   = pos_z;
   assign rows_eff = (atlas_rows == '0) ? RW'(1) : atlas_rows;

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 4; c++) begin
               prod_ff[r][c] <= pos[r] * $signed(matrix_ff[r*4+c]);
            end
         end
         for (int c = 0; c < 4; c++) begin
            bias_ff[c] <= $signed(matrix_ff[12+c]);
         end
         size1_ff <= half_size;
         slot1_ff <= particle_slot;
         ar1_ff   <= age * rows_eff;
         rows1_ff <= rows_eff;
      end
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= item_en;
      end
   end

   // Stage 2: floor each product to Q16.16 and sum the column
   logic signed [SW-1:0]        t_in [4];
   logic signed [SW-1:0]        t_ff [4];
   logic [AR_W+RW-1:0]          cell_prod;
   logic [CELL_W-1:0]           cell2_ff;
   logic [RW-1:0]               row2_ff;
   logic [RW-1:0]               rows2_ff;
   logic signed [CW-1:0]        size2_ff;
   logic [pbqe_pkg::SLOT_W-1:0] slot2_ff;
   logic                        v2_ff;

   always_comb begin
      for (int c = 0; c < 4; c++) begin
         t_in[c] = SW'(prod_ff[0][c] >>> 16) + SW'(prod_ff[1][c] >>> 16)
                 + SW'(prod_ff[2][c] >>> 16) + SW'(bias_ff[c]);
      end
   end

   assign cell_prod = ar1_ff * rows1_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int c = 0; c < 4; c++) begin
            t_ff[c] <= t_in[c];
         end
         cell2_ff <= cell_prod[AR_W+RW-1:16];
         row2_ff  <= ar1_ff[AR_W-1:16];
         rows2_ff <= rows1_ff;
         size2_ff <= size1_ff;
         slot2_ff <= slot1_ff;
      end
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (adv) begin
         v2_ff <= v1_ff;
      end
   end

   // Stage 3: magnitudes and signs for the divider, atlas column
   logic [2:0][SW-1:0]          an3_ff;
   logic [SW-1:0]               ad3_ff;
   logic [2:0]                  neg3_ff;
   logic [2:0]                  zero3_ff;
   logic                        fault3_ff;
   logic [CELL_W-1:0]           row_span;
   logic [RW-1:0]               col3_ff;
   logic [RW-1:0]               row3_ff;
   logic [RW-1:0]               rows3_ff;
   logic signed [CW-1:0]        size3_ff;
   logic [pbqe_pkg::SLOT_W-1:0] slot3_ff;
   logic                        v3_ff;

   assign row_span = row2_ff * rows2_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int l = 0; l < 3; l++) begin
            an3_ff[l]   <= t_ff[l][SW-1] ? SW'(-t_ff[l]) : SW'(t_ff[l]);
            neg3_ff[l]  <= t_ff[l][SW-1] ^ t_ff[3][SW-1];
            zero3_ff[l] <= (t_ff[l] == '0);
         end
         ad3_ff    <= t_ff[3][SW-1] ? SW'(-t_ff[3]) : SW'(t_ff[3]);
         fault3_ff <= (t_ff[3] == '0);
         col3_ff   <= RW'(cell2_ff - row_span);
         row3_ff   <= row2_ff;
         rows3_ff  <= rows2_ff;
         size3_ff  <= size2_ff;
         slot3_ff  <= slot2_ff;
      end
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (adv) begin
         v3_ff <= v2_ff;
      end
   end

   // Stage 4: quotient overflow check, texture edges through the reciprocal
   logic [pbqe_pkg::RECIP_W-1:0] recip;
   logic [KP_W-1:0]              pu0, pu1, pv0, pv1;
   logic [RW:0]                  col_k, row_k;
   pbqe_pkg::div_in_type         div_in_ff;

   assign recip = pbqe_pkg::recip_lookup(rows3_ff);
   assign col_k = {1'b0, col3_ff};
   assign row_k = {1'b0, row3_ff};
   assign pu0   = col_k * recip;
   assign pu1   = (col_k + (RW+1)'(1)) * recip;
   assign pv0   = row_k * recip;
   assign pv1   = (row_k + (RW+1)'(1)) * recip;

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int l = 0; l < 3; l++) begin
            div_in_ff.num[l]       <= an3_ff[l];
            div_in_ff.side.sat[l]  <= (SW'(an3_ff[l][SW-1:32]) >= ad3_ff) && !zero3_ff[l];
         end
         div_in_ff.den        <= ad3_ff;
         div_in_ff.side.size  <= size3_ff;
         div_in_ff.side.u0    <= pu0[pbqe_pkg::RECIP_SH+TW-1:pbqe_pkg::RECIP_SH];
         div_in_ff.side.u1    <= pu1[pbqe_pkg::RECIP_SH+TW-1:pbqe_pkg::RECIP_SH];
         div_in_ff.side.v0    <= pv0[pbqe_pkg::RECIP_SH+TW-1:pbqe_pkg::RECIP_SH];
         div_in_ff.side.v1    <= pv1[pbqe_pkg::RECIP_SH+TW-1:pbqe_pkg::RECIP_SH];
         div_in_ff.side.slot  <= slot3_ff;
         div_in_ff.side.fault <= fault3_ff;
         div_in_ff.side.neg   <= neg3_ff;
         div_in_ff.side.zero  <= zero3_ff;
      end
      if (reset) begin
         div_in_ff.valid <= 1'b0;
      end else if (adv) begin
         div_in_ff.valid <= v3_ff;
      end
   end

   assign div_in = div_in_ff;

endmodule

`default_nettype wire

>>> rtl/core/pbqe_div.sv
// ----------------------------------------------------------------------------
// pbqe_div: pipelined restoring divider, three numerators over one w
// One quotient bit per stage, 48 stages, sideband carried in step.
// ----------------------------------------------------------------------------
`default_nettype none

module pbqe_div (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  pbqe_pkg::div_in_type  div_in,
   output pbqe_pkg::div_out_type div_out
);

   localparam int unsigned SW     = pbqe_pkg::SUM_W;
   localparam int unsigned QW     = pbqe_pkg::QUO_W;
   localparam int unsigned NL     = pbqe_pkg::LANES;
   localparam int unsigned STAGES = pbqe_pkg::QUO_W;

   typedef struct packed {
      logic                 valid;
      logic [NL-1:0][SW-1:0] rem;
      logic [NL-1:0][QW-1:0] nlo;
      logic [NL-1:0][QW-1:0] quo;
      logic [SW-1:0]        den;
      pbqe_pkg::side_type   side;
   } dstage_type;

   dstage_type head;
   dstage_type stage_ff [STAGES];

   // Start: remainder holds the numerator above bit 32, low bits feed in later
   always_comb begin
      head.valid = div_in.valid;
      head.den   = div_in.den;
      head.side  = div_in.side;
      for (int l = 0; l < NL; l++) begin
         head.rem[l] = SW'(div_in.num[l][SW-1:32]);
         head.nlo[l] = {div_in.num[l][31:0], 16'b0};
         head.quo[l] = '0;
      end
   end

   for (genvar s = 0; s < STAGES; s++) begin : g_step
      dstage_type prev;
      dstage_type nxt;

      if (s == 0) begin : g_first
         assign prev = head;
      end else begin : g_next
         assign prev = stage_ff[s-1];
      end

      // Shift one numerator bit in, subtract w where it fits
      always_comb begin
         logic [SW:0] trial;
         logic        take;
         nxt = prev;
         for (int l = 0; l < NL; l++) begin
            trial = {prev.rem[l], prev.nlo[l][QW-1]};
            take  = (trial >= {1'b0, prev.den});
            nxt.rem[l] = take ? SW'(trial - {1'b0, prev.den}) : trial[SW-1:0];
            nxt.nlo[l] = {prev.nlo[l][QW-2:0], 1'b0};
            nxt.quo[l] = {prev.quo[l][QW-2:0], take};
         end
      end

      // Advance the data; valid clears on reset
      always_ff @(posedge clock) begin
         if (adv) begin
            stage_ff[s].rem  <= nxt.rem;
            stage_ff[s].nlo  <= nxt.nlo;
            stage_ff[s].quo  <= nxt.quo;
            stage_ff[s].den  <= nxt.den;
            stage_ff[s].side <= nxt.side;
         end
         if (reset) begin
            stage_ff[s].valid <= 1'b0;
         end else if (adv) begin
            stage_ff[s].valid <= nxt.valid;
         end
      end
   end

   assign div_out.valid = stage_ff[STAGES-1].valid;
   assign div_out.quo   = stage_ff[STAGES-1].quo;
   assign div_out.side  = stage_ff[STAGES-1].side;

endmodule

`default_nettype wire

>>> rtl/core/pbqe_quad.sv
// ----------------------------------------------------------------------------
// pbqe_quad: signed quotient, corner offsets and four-vertex output
// Holds one finished particle and sends its corners one transfer at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module pbqe_quad (
   input  logic                               clock,
   input  logic                               reset,
   input  pbqe_pkg::div_out_type              div_out,
   output logic                               adv,
   output logic                               out_valid,
   input  logic                               out_ready,
   output logic [pbqe_pkg::COORD_W-1:0]       vert_x,
   output logic [pbqe_pkg::COORD_W-1:0]       vert_y,
   output logic [pbqe_pkg::COORD_W-1:0]       vert_z,
   output logic [pbqe_pkg::TEX_W-1:0]         tex_u,
   output logic [pbqe_pkg::TEX_W-1:0]         tex_v,
   output logic [pbqe_pkg::VNUM_W-1:0]        vertex_number,
   output logic                               divide_fault,
   output logic                               last_vertex
);

   localparam int unsigned CW  = pbqe_pkg::COORD_W;
   localparam int unsigned QW  = pbqe_pkg::QUO_W;
   localparam int unsigned QSW = QW + 2;
   localparam int unsigned XW  = QSW + 1;
   localparam logic signed [XW-1:0] SatMax = XW'(64'sd2147483647);
   localparam logic signed [XW-1:0] SatMin = XW'(-64'sd2147483648);

   function automatic logic [CW-1:0] sat32(input logic signed [XW-1:0] v);
      logic [CW-1:0] r;
      if (v > SatMax) begin
         r = 32'h7FFF_FFFF;
      end else if (v < SatMin) begin
         r = 32'h8000_0000;
      end else begin
         r = v[CW-1:0];
      end
      return r;
   endfunction

   // Stage E: apply overflow cap, zero case and sign to each quotient
   logic signed [QSW-1:0] q_in [3];
   logic signed [QSW-1:0] q_ff [3];
   pbqe_pkg::side_type    side_e_ff;
   logic                  e_valid_ff;
   logic                  hold_ready;

   always_comb begin
      logic [QW:0] mag;
      for (int l = 0; l < 3; l++) begin
         if (div_out.side.sat[l]) begin
            mag = {1'b1, {QW{1'b0}}};
         end else if (div_out.side.zero[l]) begin
            mag = '0;
         end else begin
            mag = {1'b0, div_out.quo[l]};
         end
         q_in[l] = div_out.side.neg[l] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
      end
   end

   assign adv = !e_valid_ff || hold_ready;

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int l = 0; l < 3; l++) begin
            q_ff[l] <= q_in[l];
         end
         side_e_ff <= div_out.side;
      end
      if (reset) begin
         e_valid_ff <= 1'b0;
      end else if (adv) begin
         e_valid_ff <= div_out.valid;
      end
   end

   // Hold: both offsets of x and y, saturated, plus texture edges
   logic [CW-1:0]               x_lo_ff, x_hi_ff, y_lo_ff, y_hi_ff, z_ff;
   logic [pbqe_pkg::TEX_W-1:0]  u0_ff, u1_ff, v0_ff, v1_ff;
   logic [pbqe_pkg::SLOT_W-1:0] slot_ff;
   logic                        fault_ff;
   logic                        hold_valid_ff;
   logic [1:0]                  corner_ff;
   logic signed [XW-1:0]        size_x;
   logic                        load_hold;

   assign size_x     = XW'(side_e_ff.size);
   assign hold_ready = !hold_valid_ff || (out_ready && corner_ff == 2'd3);
   assign load_hold  = e_valid_ff && hold_ready;

   always_ff @(posedge clock) begin
      if (load_hold) begin
         x_lo_ff  <= sat32(XW'(q_ff[0]) - size_x);
         x_hi_ff  <= sat32(XW'(q_ff[0]) + size_x);
         y_lo_ff  <= sat32(XW'(q_ff[1]) - size_x);
         y_hi_ff  <= sat32(XW'(q_ff[1]) + size_x);
         z_ff     <= sat32(XW'(q_ff[2]));
         u0_ff    <= side_e_ff.u0;
         u1_ff    <= side_e_ff.u1;
         v0_ff    <= side_e_ff.v0;
         v1_ff    <= side_e_ff.v1;
         slot_ff  <= side_e_ff.slot;
         fault_ff <= side_e_ff.fault;
      end
      if (reset) begin
         hold_valid_ff <= 1'b0;
         corner_ff     <= 2'd0;
      end else if (hold_ready) begin
         hold_valid_ff <= e_valid_ff;
         corner_ff     <= 2'd0;
      end else if (out_ready) begin
         corner_ff     <= corner_ff + 2'd1;
      end
   end

   // Corner order: (-,-) (+,-) (-,+) (+,+)
   assign out_valid     = hold_valid_ff;
   assign vert_x        = corner_ff[0] ? x_hi_ff : x_lo_ff;
   assign vert_y        = corner_ff[1] ? y_hi_ff : y_lo_ff;
   assign vert_z        = z_ff;
   assign tex_u         = corner_ff[0] ? u1_ff : u0_ff;
   assign tex_v         = corner_ff[1] ? v0_ff : v1_ff;
   assign vertex_number = {slot_ff, corner_ff};
   assign divide_fault  = fault_ff;
   assign last_vertex   = (corner_ff == 2'd3);

endmodule

`default_nettype wire

>>> rtl/core/particle_billboard_quad_expander.sv
// ----------------------------------------------------------------------------
// particle_billboard_quad_expander: point sprite to textured quad
// Input stream (req_*): tuser selects a matrix word load or a particle.
// A load writes one Q16.16 word of the 4x4 transform at once and sends
// nothing out. A particle is transformed by the matrix, divided by w and
// expanded into four corner vertices with texture atlas coordinates.
// Output stream (rsp_*): one vertex per transfer, tlast on the fourth,
// tuser flags a zero w (outputs saturated).
// csr_wen/csr_wdata set the atlas cells per side; write it only when idle.
// The first vertex follows the particle through the four transform stages,
// the 48-stage divider and two output stages; up to about 54 particles may
// be in flight. Throughput: one vertex per cycle while rsp_tready is high,
// four per particle; loads go one per cycle while req_tready is high.
// Reset: matrix returns to identity, atlas rows to 1, pipeline empties.
// A stalled output holds its vertex; once stage E also holds a particle, the
// whole pipeline halts and req_tready drops, so nothing is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module particle_billboard_quad_expander (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // coeff_slot, coeff_value, pos_x, pos_y, pos_z, age, half_size,
   // particle_slot, zero pad
   input  logic [pbqe_pkg::REQ_DATA_W-1:0]      req_tdata,
   // cmd
   input  logic                                 req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // vert_x, vert_y, vert_z, tex_u, tex_v, vertex_number, zero pad
   output logic [pbqe_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // divide_fault
   output logic                                 rsp_tuser,
   output logic                                 rsp_tlast,
   input  logic                                 csr_wen,
   input  logic [pbqe_pkg::ROWS_W-1:0]          csr_wdata
);

   logic [pbqe_pkg::ROWS_W-1:0] atlas_rows_ff;
   logic                        adv;
   logic                        req_xfer;
   pbqe_pkg::cmd_type           cmd;
   pbqe_pkg::div_in_type        div_in;
   pbqe_pkg::div_out_type       div_out;

   logic [pbqe_pkg::COORD_W-1:0] vert_x, vert_y, vert_z;
   logic [pbqe_pkg::TEX_W-1:0]   tex_u, tex_v;
   logic [pbqe_pkg::VNUM_W-1:0]  vertex_number;

   // Atlas size register
   always_ff @(posedge clock) begin
      if (reset) begin
         atlas_rows_ff <= pbqe_pkg::ROWS_W'(1);
      end else if (csr_wen) begin
         atlas_rows_ff <= csr_wdata;
      end
   end

   assign req_tready = adv;
   assign req_xfer   = req_tvalid && adv;
   assign cmd        = pbqe_pkg::cmd_type'(req_tuser);

   pbqe_front u_front (
      .clock         (clock),
      .reset         (reset),
      .adv           (adv),
      .load_en       (req_xfer && cmd == pbqe_pkg::CMD_LOAD),
      .load_slot     (req_tdata[3:0]),
      .load_value    (req_tdata[35:4]),
      .item_en       (req_xfer && cmd == pbqe_pkg::CMD_EXPAND),
      .pos_x         ($signed(req_tdata[67:36])),
      .pos_y         ($signed(req_tdata[99:68])),
      .pos_z         ($signed(req_tdata[131:100])),
      .age           (req_tdata[147:132]),
      .half_size     ($signed(req_tdata[179:148])),
      .particle_slot (req_tdata[193:180]),
      .atlas_rows    (atlas_rows_ff),
      .div_in        (div_in)
   );

   pbqe_div u_div (
      .clock   (clock),
      .reset   (reset),
      .adv     (adv),
      .div_in  (div_in),
      .div_out (div_out)
   );

   pbqe_quad u_quad (
      .clock         (clock),
      .reset         (reset),
      .div_out       (div_out),
      .adv           (adv),
      .out_valid     (rsp_tvalid),
      .out_ready     (rsp_tready),
      .vert_x        (vert_x),
      .vert_y        (vert_y),
      .vert_z        (vert_z),
      .tex_u         (tex_u),
      .tex_v         (tex_v),
      .vertex_number (vertex_number),
      .divide_fault  (rsp_tuser),
      .last_vertex   (rsp_tlast)
   );

   // Pack the vertex, lowest field first
   assign rsp_tdata = {6'b0, vertex_number, tex_v, tex_u, vert_z, vert_y, vert_x};

endmodule

`default_nettype wire

>>> rtl/core/pbqe_checker.sv
// ----------------------------------------------------------------------------
// pbqe_checker: port-level checks of the quad expander
// Watches the output stream for corner sequencing and stall behavior.
// ----------------------------------------------------------------------------
`default_nettype none

module pbqe_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [pbqe_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input logic                              rsp_tuser,
   input logic                              rsp_tlast
);

   // A stalled vertex holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled vertex changed");

   // tlast marks corner three
   a_last_corner: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tdata[131:130] == 2'b11)))
      else $error("tlast does not match corner");

   // Corners of one quad follow back to back from the same particle
   a_quad_run: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=>
         rsp_tvalid && rsp_tdata[145:132] == $past(rsp_tdata[145:132])
         && rsp_tdata[131:130] == $past(rsp_tdata[131:130]) + 2'd1
         && rsp_tuser == $past(rsp_tuser))
      else $error("quad corners broken up");

   // Reset empties the output
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("output valid after reset");

endmodule

bind particle_billboard_quad_expander pbqe_checker u_checker (.*);

`default_nettype wire
